// ----- rtl/fit_memory_allocator_core_macros.svh -----
// Assertion macros used by the checker file of the fit allocator.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FIT_MEMORY_ALLOCATOR_CORE_MACROS_SVH
`define FIT_MEMORY_ALLOCATOR_CORE_MACROS_SVH

// Checks a property in the same cycle as its antecedent.
`define FMA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a property in the cycle after its antecedent.
`define FMA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fma_pkg.sv -----
// Shared types and constants of the fit memory allocator.
// Used by the cell, the top level and the checker; depends on nothing.
package fma_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    localparam int SIZE_FIELD_BITS  = 16;
    localparam int INDEX_FIELD_BITS = 4;
    localparam int CFG_DATA_BITS    = 5;
    localparam int CFG_INDEX_BITS   = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FIT_MODE    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_COUNT = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] BLOCK_COUNT_RESET = 5'd16;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    typedef struct packed {
        logic                        kind;
        logic [INDEX_FIELD_BITS-1:0] block_index;
        logic [SIZE_FIELD_BITS-1:0]  size;
    } req_t;

    typedef struct packed {
        logic                        allocated;
        logic [INDEX_FIELD_BITS-1:0] chosen_block;
    } rsp_t;

    // Search token that walks down the row of cells.
    typedef struct packed {
        logic                 active;
        logic [SIZE_BITS-1:0] need;
        logic                 found;
        logic [IDX_BITS-1:0]  best_idx;
        logic [SIZE_BITS-1:0] best_val;
    } tok_t;

    // Write command broadcast to every cell.
    typedef struct packed {
        logic                 load;
        logic                 charge;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] value;
    } cmd_t;

endpackage

// ----- rtl/fma_cell.sv -----
// One cell of the allocator row: holds one free-size entry and updates the
// passing search token. Depends on fma_pkg.
module fma_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fma_pkg::IDX_BITS-1:0]  cell_id,
    input  logic                          part,
    input  logic [1:0]                    fit_mode,
    input  fma_pkg::cmd_t                 cmd,
    input  fma_pkg::tok_t                 tok_in,
    output fma_pkg::tok_t                 tok_out
);

    logic [fma_pkg::SIZE_BITS-1:0] entry_reg;
    logic [fma_pkg::SIZE_BITS-1:0] entry_next;
    fma_pkg::tok_t                 tok_reg;
    fma_pkg::tok_t                 tok_next;
    logic                          hit;
    logic                          better;
    logic                          take;

    always_comb
    begin
        hit    = tok_in.active && part && (entry_reg >= tok_in.need);
        better = ((fit_mode == fma_pkg::MODE_BEST) && (entry_reg < tok_in.best_val)) ||
                 ((fit_mode == fma_pkg::MODE_WORST) && (entry_reg > tok_in.best_val));
        take   = hit && (!tok_in.found || better);

        tok_next = tok_in;
        if (take)
        begin
            tok_next.found    = 1'b1;
            tok_next.best_idx = cell_id;
            tok_next.best_val = entry_reg;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.load && (cmd.idx == cell_id))
        begin
            entry_next = cmd.value;
        end
        else if (cmd.charge && (cmd.idx == cell_id))
        begin
            entry_next = entry_reg - cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/fit_memory_allocator_core.sv -----
// Top level of the fit memory allocator: configuration registers, control
// and a row of fma_cell instances. Depends on fma_pkg and fma_cell.
//
//   channel   direction   handshake             payload
//   in        input       in_valid / in_ready   in_data   (fma_pkg::req_t)
//   out       output      out_valid / out_ready out_data  (fma_pkg::rsp_t)
//   cfg       input       cfg_we                cfg_index, cfg_wdata
//
// A load produces no result.
// A request walks the row of NUM_BLOCKS cells, one cell per cycle, and the
// next item is taken only once its result has been passed to the output
// register and its write-back to the table has been done.
// A result waiting in the output register does not block a new item; only the
// write-back of the following request waits for the output to drain.
// Reset clears control, sets the fit mode to first fit and the block count to 16; table entries stay undefined.
module fit_memory_allocator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  fma_pkg::req_t                        in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output fma_pkg::rsp_t                        out_data,
    input  logic                                 cfg_we,
    input  logic [fma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fma_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    logic [1:0]                         fit_mode_reg;
    logic [fma_pkg::CFG_DATA_BITS-1:0]  block_count_reg;
    fma_pkg::tok_t                      hold_reg;
    logic                               out_valid_reg;
    fma_pkg::rsp_t                      out_data_reg;
    fma_pkg::rsp_t                      out_data_next;

    fma_pkg::tok_t                      chain [fma_pkg::NUM_BLOCKS+1];
    fma_pkg::tok_t                      head_tok;
    logic [fma_pkg::NUM_BLOCKS-1:0]     part;
    fma_pkg::tok_t                      final_tok;
    fma_pkg::cmd_t                      cmd;
    logic                               in_accept;
    logic                               done;
    logic                               fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        head_tok          = '0;
        head_tok.active   = in_accept && (in_data.kind == fma_pkg::KIND_ALLOC);
        head_tok.need     = fma_pkg::SIZE_BITS'(in_data.size);
    end

    assign chain[0] = head_tok;

    genvar k;
    generate
        for (k = 0; k < fma_pkg::NUM_BLOCKS; k++)
        begin : g_cell
            assign part[k] = (int'(block_count_reg) > k);

            fma_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_id  (fma_pkg::IDX_BITS'(k)),
                .part     (part[k]),
                .fit_mode (fit_mode_reg),
                .cmd      (cmd),
                .tok_in   (chain[k]),
                .tok_out  (chain[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        final_tok = (state_reg == ST_HOLD) ? hold_reg : chain[fma_pkg::NUM_BLOCKS];
        done      = ((state_reg == ST_RUN) && chain[fma_pkg::NUM_BLOCKS].active) ||
                    (state_reg == ST_HOLD);
        fire      = done && (!out_valid_reg || out_ready);

        cmd.load   = in_accept && (in_data.kind == fma_pkg::KIND_LOAD) &&
                     (int'(in_data.block_index) < fma_pkg::NUM_BLOCKS);
        cmd.charge = fire && final_tok.found;
        cmd.idx    = cmd.load ? fma_pkg::IDX_BITS'(in_data.block_index) : final_tok.best_idx;
        cmd.value  = cmd.load ? fma_pkg::SIZE_BITS'(in_data.size) : final_tok.need;

        out_data_next.allocated    = final_tok.found;
        out_data_next.chosen_block = final_tok.found ?
                                     fma_pkg::INDEX_FIELD_BITS'(final_tok.best_idx) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_data.kind == fma_pkg::KIND_ALLOC))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    state_next = fire ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            fit_mode_reg    <= fma_pkg::MODE_FIRST;
            block_count_reg <= fma_pkg::BLOCK_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fma_pkg::REG_FIT_MODE:    fit_mode_reg    <= cfg_wdata[1:0];
                    fma_pkg::REG_BLOCK_COUNT: block_count_reg <= cfg_wdata;
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RUN) && chain[fma_pkg::NUM_BLOCKS].active)
        begin
            hold_reg <= chain[fma_pkg::NUM_BLOCKS];
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/fma_checker.sv -----
// Port-level checker for the fit memory allocator and its bind statement.
// Depends on fma_pkg and fit_memory_allocator_core_macros.svh.
`include "fit_memory_allocator_core_macros.svh"

module fma_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  fma_pkg::req_t                        in_data,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  fma_pkg::rsp_t                        out_data
);

    // A stalled result must hold its value.
    `FMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

    // A refused request reports block zero.
    `FMA_ASSERT_NOW(a_no_alloc_zero, out_valid && !out_data.allocated, out_data.chosen_block == '0, "unallocated result names a block")

    // A load never produces a result.
    `FMA_ASSERT_NEXT(a_load_silent, in_valid && in_ready && (in_data.kind == fma_pkg::KIND_LOAD) && !out_valid, !out_valid, "load produced a result")

    // An accepted request occupies the block while it searches.
    `FMA_ASSERT_NEXT(a_alloc_busy, in_valid && in_ready && (in_data.kind == fma_pkg::KIND_ALLOC), !in_ready, "block ready right after a request")

endmodule

bind fit_memory_allocator_core fma_checker u_fma_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for fit_memory_allocator_core: a directed table, then random requests
// under several placement settings, checked against a local model of the free-size table or a row's expected result.
// Depends on fma_pkg and the fit_memory_allocator_core RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES = fma_pkg::NUM_BLOCKS + 4;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SEG_ITEMS     = 46;
    localparam int NUM_SEGS      = 12;
    localparam int DIR_ROWS      = 32;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic                               T_LOAD  = fma_pkg::KIND_LOAD;
    localparam logic                               T_ALLOC = fma_pkg::KIND_ALLOC;
    localparam logic [fma_pkg::CFG_INDEX_BITS-1:0] T_MODE  = fma_pkg::REG_FIT_MODE;
    localparam logic [fma_pkg::CFG_INDEX_BITS-1:0] T_COUNT = fma_pkg::REG_BLOCK_COUNT;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [fma_pkg::CFG_INDEX_BITS-1:0] reg_idx;
        logic [fma_pkg::CFG_DATA_BITS-1:0]  reg_data;
        fma_pkg::req_t                      req;
        logic                               typed;
        fma_pkg::rsp_t                      want;
    } dir_row_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    fma_pkg::req_t                      in_data   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    fma_pkg::rsp_t                      out_data;
    logic                               cfg_we    = 1'b0;
    logic [fma_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [fma_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    logic [fma_pkg::SIZE_BITS-1:0]     free_left [fma_pkg::NUM_BLOCKS];
    logic [1:0]                        fit_mode_sh    = fma_pkg::MODE_FIRST;
    logic [fma_pkg::CFG_DATA_BITS-1:0] block_count_sh = fma_pkg::BLOCK_COUNT_RESET;
    fma_pkg::rsp_t                     pending_grants [$];

    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int errors       = 0;
    int cycles       = 0;

    logic [fma_pkg::CFG_DATA_BITS-1:0] seg_count [NUM_SEGS] =
        '{5'd16, 5'd1, 5'd31, 5'd7, 5'd16, 5'd2, 5'd0, 5'd17, 5'd16, 5'd12, 5'd31, 5'd5};

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd0, 16'hFFFF}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd1, 16'h0000}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd2, 16'd100}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd3, 16'd50}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd4, 16'd100}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd5, 16'hFFFF}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd6, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd7, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd8, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd9, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd10, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd11, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd12, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd13, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd14, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_LOAD, 4'd15, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd0, 16'hFFFF}, 1'b1, '{1'b1, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd15, 16'h0000}, 1'b1, '{1'b1, 4'd0}},
        '{ROW_REG, T_MODE, {3'b000, fma_pkg::MODE_BEST}, '0, 1'b0, '0},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd9, 16'd50}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd6, 16'd100}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_REG, T_MODE, {3'b000, fma_pkg::MODE_WORST}, '0, 1'b0, '0},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd3, 16'd1}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd12, 16'd100}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_REG, T_COUNT, 5'd0, '0, 1'b0, '0},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd5, 16'h0000}, 1'b1, '{1'b0, 4'd0}},
        '{ROW_REG, T_COUNT, 5'd31, '0, 1'b0, '0},
        '{ROW_REG, T_MODE, {3'b000, MODE_UNUSED}, '0, 1'b0, '0},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd10, 16'd30}, 1'b0, '{1'b0, 4'd0}},
        '{ROW_REG, T_COUNT, 5'd1, '0, 1'b0, '0},
        '{ROW_REG, T_MODE, {3'b000, fma_pkg::MODE_BEST}, '0, 1'b0, '0},
        '{ROW_ITEM, T_MODE, 5'd0, '{T_ALLOC, 4'd1, 16'hFFFF}, 1'b1, '{1'b0, 4'd0}}
    };

    fit_memory_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** fit_memory_allocator_core: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [4:0] got, logic [4:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        fma_pkg::rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_grants.size() == 0)
            begin
                report_mismatch("unexpected result", out_data, 5'd0);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (out_data.allocated !== want.allocated)
                begin
                    report_mismatch("allocated", {4'b0000, out_data.allocated},
                                    {4'b0000, want.allocated});
                end
                if (out_data.chosen_block !== want.chosen_block)
                begin
                    report_mismatch("chosen_block", {1'b0, out_data.chosen_block},
                                    {1'b0, want.chosen_block});
                end
            end
        end
    end

    // Updates the free-size table for one accepted request; an allocation queues its expected result.
    task automatic apply_request(fma_pkg::req_t r, logic typed, fma_pkg::rsp_t want);
        int                           lim;
        logic [fma_pkg::IDX_BITS-1:0] pick;
        logic [fma_pkg::IDX_BITS-1:0] jdx;
        logic                         found;
        fma_pkg::rsp_t                grant;
        if (r.kind == fma_pkg::KIND_LOAD)
        begin
            free_left[r.block_index] = r.size;
        end
        else
        begin
            lim   = (block_count_sh > fma_pkg::NUM_BLOCKS) ? fma_pkg::NUM_BLOCKS :
                    int'(block_count_sh);
            found = 1'b0;
            pick  = '0;
            grant = '0;
            for (int j = 0; j < lim; j++)
            begin
                jdx = fma_pkg::IDX_BITS'(j);
                if (free_left[jdx] >= r.size)
                begin
                    if (!found)
                    begin
                        found = 1'b1;
                        pick  = jdx;
                    end
                    else if (fit_mode_sh == fma_pkg::MODE_BEST &&
                             free_left[jdx] < free_left[pick])
                    begin
                        pick = jdx;
                    end
                    else if (fit_mode_sh == fma_pkg::MODE_WORST &&
                             free_left[jdx] > free_left[pick])
                    begin
                        pick = jdx;
                    end
                end
            end
            if (found)
            begin
                free_left[pick]    = free_left[pick] - r.size;
                grant.allocated    = 1'b1;
                grant.chosen_block = fma_pkg::INDEX_FIELD_BITS'(pick);
            end
            pending_grants.push_back(typed ? want : grant);
        end
    endtask

    task automatic push_request(fma_pkg::req_t r, logic typed, fma_pkg::rsp_t want);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        apply_request(r, typed, want);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [fma_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [fma_pkg::CFG_DATA_BITS-1:0] data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fma_pkg::REG_FIT_MODE)
        begin
            fit_mode_sh = data[1:0];
        end
        else
        begin
            block_count_sh = data;
        end
    endtask

    // Loads favor a few shared values so that best and worst fit see ties.
    function automatic fma_pkg::req_t make_request();
        fma_pkg::req_t r;
        r.kind        = ($urandom_range(99) < 35) ? fma_pkg::KIND_LOAD : fma_pkg::KIND_ALLOC;
        r.block_index = fma_pkg::INDEX_FIELD_BITS'($urandom);
        if (r.kind == fma_pkg::KIND_LOAD)
        begin
            case ($urandom_range(9))
                0:       r.size = '0;
                1:       r.size = '1;
                2:       r.size = 16'd500;
                3:       r.size = 16'd1000;
                default: r.size = fma_pkg::SIZE_FIELD_BITS'($urandom);
            endcase
        end
        else
        begin
            case ($urandom_range(9))
                0:       r.size = '0;
                1:       r.size = '1;
                2:       r.size = fma_pkg::SIZE_FIELD_BITS'($urandom);
                default: r.size = fma_pkg::SIZE_FIELD_BITS'($urandom_range(1500));
            endcase
        end
        return r;
    endfunction

    initial
    begin
        logic [fma_pkg::CFG_DATA_BITS-1:0] mode_word;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end
            else
            begin
                push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            case (seg / 4)
                0:
                begin
                    in_idle_pct  = 9;
                    out_idle_pct = 75;
                end
                1:
                begin
                    in_idle_pct  = 75;
                    out_idle_pct = 9;
                end
                default:
                begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            mode_word      = fma_pkg::CFG_DATA_BITS'($urandom);
            mode_word[1:0] = 2'(seg % 4);
            write_reg(fma_pkg::REG_FIT_MODE, mode_word);
            write_reg(fma_pkg::REG_BLOCK_COUNT, seg_count[seg]);
            repeat (SEG_ITEMS) push_request(make_request(), 1'b0, '0);
        end

        wait_idle();
        if (errors == 0)
        begin
            $display("** fit_memory_allocator_core: PASSED **");
        end
        else
        begin
            $display("** fit_memory_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule
